// ----- rtl/core/tnm_pkg.sv -----
// Package for the multichannel NCO complex mixer.
// Holds sizes, codes, the queue entry type and the fixed-point helper functions.
// Depends on nothing.
`default_nettype none
package tnm_pkg;

  localparam int CHANNELS     = 16;
  localparam int CHAN_W       = 4;
  localparam int GROUP_LEN    = 8;
  localparam int POS_W        = $clog2(GROUP_LEN);
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CW           = 34;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic CMD_MIX   = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic signed [15:0] sre;
    logic signed [15:0] sim;
    logic [31:0]        ramp_ph;
    logic [31:0]        blk_ph;
  } tnm_job_t;

  function automatic logic signed [CW-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic signed [CW-1:0] a;
    case (i)
      5'd0:    a = 34'sh020000000;
      5'd1:    a = 34'sh012E4051E;
      5'd2:    a = 34'sh009FB385B;
      5'd3:    a = 34'sh0051111D4;
      5'd4:    a = 34'sh0028B0D43;
      5'd5:    a = 34'sh00145D7E1;
      5'd6:    a = 34'sh000A2F61E;
      5'd7:    a = 34'sh000517C55;
      5'd8:    a = 34'sh00028BE53;
      5'd9:    a = 34'sh000145F2F;
      5'd10:   a = 34'sh0000A2F98;
      5'd11:   a = 34'sh0000517CC;
      5'd12:   a = 34'sh000028BE6;
      5'd13:   a = 34'sh0000145F3;
      5'd14:   a = 34'sh00000A2FA;
      5'd15:   a = 34'sh00000517D;
      5'd16:   a = 34'sh0000028BE;
      5'd17:   a = 34'sh00000145F;
      5'd18:   a = 34'sh000000A30;
      5'd19:   a = 34'sh000000518;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Clamp a 20-bit signed value into Q1.15.
  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Shift right by 15 with rounding half away from zero, then saturate.
  function automatic logic signed [15:0] round_sym15(input logic signed [32:0] v);
    logic        neg;
    logic [33:0] mag;
    logic [18:0] r;
    logic signed [19:0] s;
    neg = v[32];
    mag = neg ? 34'(-34'(v)) : 34'(v);
    r   = 19'((mag + 34'd16384) >> 15);
    s   = neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    return sat16(s);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tnm_queue.sv -----
// Short job queue between the front end and the mixing back end.
// Uses tnm_pkg for the entry type and depth.
`default_nettype none
module tnm_queue import tnm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr,
  input  wire tnm_job_t wdata,
  input  wire logic     rd,
  output tnm_job_t      rdata,
  output logic          q_full,
  output logic          q_empty
);

  tnm_job_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wptr;
  logic [Q_PTR_W-1:0]   rptr;
  logic [Q_CNT_W-1:0]   cnt;
  logic                 do_wr;
  logic                 do_rd;

  assign q_full  = (cnt == Q_CNT_W'(Q_DEPTH));
  assign q_empty = (cnt == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      cnt <= Q_CNT_W'(cnt + Q_CNT_W'(do_wr) - Q_CNT_W'(do_rd));
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tnm_front.sv -----
// Front end: accepts transactions, keeps the per-channel phase, increment and
// position tables, and queues sample jobs with both angles. Uses tnm_pkg.
`default_nettype none
module tnm_front import tnm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic               cmd,
  input  wire logic [CHAN_W-1:0]  chan,
  input  wire logic signed [15:0] sample_re,
  input  wire logic signed [15:0] sample_im,
  input  wire logic signed [31:0] incr_value,
  output logic                    job_wr,
  output tnm_job_t                job
);

  logic [31:0]      phase_tbl [CHANNELS];
  logic [31:0]      incr_tbl  [CHANNELS];
  logic [POS_W-1:0] pos_tbl   [CHANNELS];
  logic             ch_ok;
  logic [31:0]      incr;
  logic [POS_W-1:0] pos;

  assign ch_ok = (int'(chan) < CHANNELS);
  assign incr  = incr_tbl[chan];
  assign pos   = pos_tbl[chan];

  assign job_wr       = accept && ch_ok && (cmd == CMD_MIX);
  assign job.chan     = chan;
  assign job.sre      = sample_re;
  assign job.sim      = sample_im;
  assign job.ramp_ph  = 32'(incr * 32'(pos));
  assign job.blk_ph   = phase_tbl[chan];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_tbl[i] <= '0;
        incr_tbl[i]  <= '0;
        pos_tbl[i]   <= '0;
      end
    end else if (accept && ch_ok) begin
      if (cmd == CMD_WRITE) begin
        incr_tbl[chan] <= incr_value;
      end else begin
        pos_tbl[chan] <= pos + 1'b1;
        // The block phase moves on once the last sample of a group has been accepted.
        if (pos == POS_W'(GROUP_LEN - 1)) begin
          phase_tbl[chan] <= phase_tbl[chan] + (incr << POS_W);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tnm_back.sv -----
// Back end: one shared CORDIC rotator for the ramp and block-phase sinusoids,
// then two complex Q1.15 products through one set of four multipliers.
// Uses tnm_pkg.
`default_nettype none
module tnm_back import tnm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire tnm_job_t    job,
  input  wire logic        q_empty,
  output logic             q_rd,
  input  wire logic        pop,
  output logic             empty,
  output logic signed [15:0] out_re,
  output logic signed [15:0] out_im,
  output logic [CHAN_W-1:0]  out_chan
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ROT  = 6'b000010,
    S_MIX  = 6'b000100,
    S_MIXR = 6'b001000,
    S_OUTM = 6'b010000,
    S_OUTR = 6'b100000
  } state_t;

  state_t               state;
  state_t               state_next;
  tnm_job_t             cur;
  logic                 pass;
  logic [STEP_W-1:0]    step;
  logic signed [CW-1:0] x, y, z;
  logic signed [CW-1:0] dx, dy, at;
  logic signed [CW-1:0] x_next, y_next, z_next;
  logic signed [15:0]   rc, rs, pc, ps, mr, mi;
  logic signed [15:0]   ar, ai, br, bi;
  logic signed [31:0]   p0, p1, p2, p3;
  logic signed [32:0]   sum_re, sum_im;
  logic signed [15:0]   c_fin, s_fin;
  logic                 out_valid;
  logic                 out_free;
  logic                 last_step;

  // Start a rotation: phases in the left half-plane are turned by half a turn.
  function automatic logic signed [CW-1:0] init_x(input logic [31:0] ph);
    logic fold;
    fold = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
    return fold ? -GAIN_INV : GAIN_INV;
  endfunction

  function automatic logic signed [CW-1:0] init_z(input logic [31:0] ph);
    logic fold;
    fold = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
    return CW'($signed(ph ^ {fold, 31'b0}));
  endfunction

  assign empty     = !out_valid;
  assign out_free  = !out_valid || pop;
  assign q_rd      = (state == S_IDLE) && !q_empty;
  assign last_step = (step == STEP_W'(CORDIC_STEPS - 1));

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign at = atan_lut(step);
  always_comb begin
    if (!z[CW-1]) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - at;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + at;
    end
  end

  assign c_fin = sat16(20'((x_next + CW'(16384)) >>> 15));
  assign s_fin = sat16(20'((y_next + CW'(16384)) >>> 15));

  // Operands of the shared multipliers: mixer product first, then the sample.
  always_comb begin
    if (state == S_MIX) begin
      ar = rc; ai = rs; br = pc; bi = ps;
    end else begin
      ar = cur.sre; ai = cur.sim; br = mr; bi = mi;
    end
  end

  assign sum_re = 33'(p0) - 33'(p1);
  assign sum_im = 33'(p2) + 33'(p3);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (!q_empty) state_next = S_ROT;
      S_ROT:   if (last_step && pass) state_next = S_MIX;
      S_MIX:   state_next = S_MIXR;
      S_MIXR:  state_next = S_OUTM;
      S_OUTM:  state_next = S_OUTR;
      S_OUTR:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // In the output state a popped result is replaced by the new one below.
      if (pop && out_valid && (state != S_OUTR)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur  <= job;
            pass <= 1'b0;
            step <= '0;
            x    <= init_x(job.ramp_ph);
            z    <= init_z(job.ramp_ph);
            y    <= '0;
          end
        end
        S_ROT: begin
          if (last_step) begin
            step <= '0;
            if (!pass) begin
              rc   <= c_fin;
              rs   <= s_fin;
              pass <= 1'b1;
              x    <= init_x(cur.blk_ph);
              z    <= init_z(cur.blk_ph);
              y    <= '0;
            end else begin
              pc   <= c_fin;
              ps   <= s_fin;
              pass <= 1'b0;
            end
          end else begin
            step <= step + 1'b1;
            x    <= x_next;
            y    <= y_next;
            z    <= z_next;
          end
        end
        S_MIX, S_OUTM: begin
          p0 <= ar * br;
          p1 <= ai * bi;
          p2 <= ar * bi;
          p3 <= ai * br;
        end
        S_MIXR: begin
          mr <= round_sym15(sum_re);
          mi <= round_sym15(sum_im);
        end
        S_OUTR: begin
          if (out_free) begin
            out_re    <= round_sym15(sum_re);
            out_im    <= round_sym15(sum_im);
            out_chan  <= cur.chan;
            out_valid <= 1'b1;
          end else if (pop && out_valid) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT) |-> (step <= STEP_W'(CORDIC_STEPS - 1)))
    else $error("CORDIC step counter ran past the last step");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUTR)
    else $error("result appeared outside the output state");

  a_pass_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIX) |-> !pass)
    else $error("rotator pass flag left set after both rotations");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> $stable(out_re) && $stable(out_im))
    else $error("waiting result overwritten");

endmodule
`default_nettype wire

// ----- rtl/core/tdm_nco_complex_mixer_core.sv -----
// Top level of the multichannel NCO complex mixer.
// Instantiates tnm_front, tnm_queue and tnm_back; uses tnm_pkg.
//
// Sixteen channels each keep a block phase, a phase increment and a group
// position. A write transaction (cmd high) loads a channel's increment. A
// sample transaction is classified in the front end, which updates the
// channel's tables at once and queues the job; the back end then runs each
// sample through two 20-step passes of one shared CORDIC rotator (ramp and
// block phase), followed by two complex products through one set of four
// 16x16 multipliers. Up to two jobs wait in the queue, and a finished
// result waits in the output register while the next job proceeds.
`default_nettype none
module tdm_nco_complex_mixer_core import tnm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               cmd,
  input  wire logic [CHAN_W-1:0]  chan,
  input  wire logic signed [15:0] sample_re,
  input  wire logic signed [15:0] sample_im,
  input  wire logic signed [31:0] incr_value,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      out_re,
  output logic signed [15:0]      out_im,
  output logic [CHAN_W-1:0]       out_chan
);

  logic     accept;
  logic     job_wr;
  tnm_job_t job_in;
  tnm_job_t job_out;
  logic     q_rd;
  logic     q_full;
  logic     q_empty;

  assign full   = q_full;
  assign accept = push && !q_full;

  tnm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd),
    .chan       (chan),
    .sample_re  (sample_re),
    .sample_im  (sample_im),
    .incr_value (incr_value),
    .job_wr     (job_wr),
    .job        (job_in)
  );

  tnm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_wr),
    .wdata   (job_in),
    .rd      (q_rd),
    .rdata   (job_out),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  tnm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (job_out),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_re   (out_re),
    .out_im   (out_im),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire
